/* sv/tcpcq_pkg.sv */
`default_nettype none

package tcpcq_pkg;

  // Default number of calls held across all classes
  localparam int unsigned CAPACITY_DEF = 64;

  // Payload widths
  localparam int unsigned NumW      = 30;
  localparam int unsigned PacketsW  = 16;
  localparam int unsigned PartyW    = 2 * NumW;
  localparam int unsigned ExtraW    = PacketsW + 2;
  localparam int unsigned DismissW  = 7;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned InUserW   = 3;
  localparam int unsigned OutDataW  = 88;
  localparam int unsigned OutUserW  = 2;

  // Request codes
  typedef enum logic [2:0] {
    REQ_INS_DATA  = 3'd0,
    REQ_INS_VOICE = 3'd1,
    REQ_INS_EMERG = 3'd2,
    REQ_SERVE     = 3'd3,
    REQ_DISMISS   = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_FULL       = 2'd2,
    ST_NO_DISMISS = 2'd3
  } status_e;

  // Call classes
  typedef enum logic [1:0] {
    CLS_DATA  = 2'd0,
    CLS_VOICE = 2'd1,
    CLS_EMERG = 2'd2
  } class_e;

  // Controller states
  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_SERVE = 1'b1
  } fsm_e;

endpackage

`default_nettype wire

/* sv/three_class_priority_call_queue_top.sv */
`default_nettype none

// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tuser: req_type; s_tdata: call record
// m_       out  m_tvalid/m_tready   m_tuser: status; m_tdata: served call, dismissed count
//
// Insert, dismiss and unknown requests are answered from the idle state; a serve
// of a held call goes through the serve state, as its record comes from the store read.
// The result sits in an output register; a new item is taken only when that
// register is empty or is being read in the same cycle.
// Reset clears heads, counts and the handshake state; store contents stay undefined.
// A stalled output blocks new items while the output register is full, and a
// serve blocks them until its record is loaded into the output register.

module three_class_priority_call_queue_top #(
  parameter int unsigned CAPACITY = tcpcq_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  // [29:0] calling_number, [59:30] called_number, [75:60] packet_count,
  // [76] roaming_on, [77] show_caller, [79:78] zero
  input  wire logic [tcpcq_pkg::InDataW-1:0]     s_tdata_i,
  // [2:0] req_type
  input  wire logic [tcpcq_pkg::InUserW-1:0]     s_tuser_i,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  // [1:0] served_class, [31:2] served_calling, [61:32] served_called,
  // [77:62] served_packets, [78] served_roaming, [79] served_show_caller,
  // [86:80] dismissed_count, [87] zero
  output logic [tcpcq_pkg::OutDataW-1:0]         m_tdata_o,
  // [1:0] status
  output logic [tcpcq_pkg::OutUserW-1:0]         m_tuser_o
);

  localparam int unsigned Depth = 3 * CAPACITY;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned HW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned NumW  = tcpcq_pkg::NumW;
  localparam int unsigned PktW  = tcpcq_pkg::PacketsW;
  localparam int unsigned DisW  = tcpcq_pkg::DismissW;

  localparam logic [AW-1:0]   BaseVoice = AW'(CAPACITY);
  localparam logic [AW-1:0]   BaseEmerg = AW'(2 * CAPACITY);
  localparam logic [CW:0]     CapWide   = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0]   CapCount  = CW'(CAPACITY);

  // Call store: party numbers and class extras
  logic [tcpcq_pkg::PartyW-1:0] party_mem [Depth];
  logic [tcpcq_pkg::ExtraW-1:0] extra_mem [Depth];
  logic [tcpcq_pkg::PartyW-1:0] rd_party_q;
  logic [tcpcq_pkg::ExtraW-1:0] rd_extra_q;

  // Ring control per class
  logic [HW-1:0] head_q  [3];
  logic [HW-1:0] head_d  [3];
  logic [CW-1:0] count_q [3];
  logic [CW-1:0] count_d [3];
  logic [CW-1:0] total_q, total_d;

  tcpcq_pkg::fsm_e   state_q, state_d;
  tcpcq_pkg::class_e srv_cls_q, srv_cls_d;

  logic                           m_tvalid_q, m_tvalid_d;
  logic [tcpcq_pkg::OutDataW-1:0] m_tdata_q, m_tdata_d;
  logic [tcpcq_pkg::OutUserW-1:0] m_tuser_q, m_tuser_d;

  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_addr;
  logic [tcpcq_pkg::PartyW-1:0]   wr_party;
  logic [tcpcq_pkg::ExtraW-1:0]   wr_extra;

  logic                           out_free, accept;

  // Input fields
  logic [NumW-1:0]  in_calling, in_called;
  logic [PktW-1:0]  in_packets;
  logic             in_roaming, in_show;

  assign in_calling = s_tdata_i[NumW-1:0];
  assign in_called  = s_tdata_i[2*NumW-1:NumW];
  assign in_packets = s_tdata_i[2*NumW+PktW-1:2*NumW];
  assign in_roaming = s_tdata_i[2*NumW+PktW];
  assign in_show    = s_tdata_i[2*NumW+PktW+1];

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == tcpcq_pkg::FSM_IDLE) && out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  // Next state, ring updates, store access and result
  always_comb begin
    logic [1:0]       cls;
    logic [CW:0]      pos_w;
    logic [HW-1:0]    pos;
    logic [HW:0]      head_inc;
    logic [AW-1:0]    base;
    logic [CW+DisW-1:0] dis_w;
    logic [PktW-1:0]  o_pkts;
    logic             o_roam, o_show;

    state_d    = state_q;
    srv_cls_d  = srv_cls_q;
    total_d    = total_q;
    for (int i = 0; i < 3; i++) begin
      head_d[i]  = head_q[i];
      count_d[i] = count_q[i];
    end
    m_tvalid_d = m_tready_i ? 1'b0 : m_tvalid_q;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = '0;
    wr_party   = {in_calling, in_called};
    wr_extra   = '0;
    cls        = s_tuser_i[1:0];
    pos_w      = '0;
    pos        = '0;
    head_inc   = '0;
    base       = '0;
    dis_w      = '0;
    o_pkts     = '0;
    o_roam     = 1'b0;
    o_show     = 1'b0;

    case (state_q)
      tcpcq_pkg::FSM_IDLE: begin
        if (accept) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = '0;
          m_tuser_d  = tcpcq_pkg::ST_OK;
          case (tcpcq_pkg::req_e'(s_tuser_i))
            tcpcq_pkg::REQ_INS_DATA, tcpcq_pkg::REQ_INS_VOICE,
            tcpcq_pkg::REQ_INS_EMERG: begin
              if (total_q >= CapCount) begin
                m_tuser_d = tcpcq_pkg::ST_FULL;
              end else begin
                // Append at head plus count, wrapped within the class ring
                pos_w = (CW + 1)'(head_q[cls]) + {1'b0, count_q[cls]};
                if (pos_w >= CapWide) begin
                  pos_w = pos_w - CapWide;
                end
                pos = pos_w[HW-1:0];
                case (cls)
                  tcpcq_pkg::CLS_VOICE: base = BaseVoice;
                  tcpcq_pkg::CLS_EMERG: base = BaseEmerg;
                  default:              base = '0;
                endcase
                mem_addr = base + AW'(pos);
                if (cls == tcpcq_pkg::CLS_DATA) begin
                  wr_extra = {in_packets, 2'b00};
                end else if (cls == tcpcq_pkg::CLS_VOICE) begin
                  wr_extra = {{PktW{1'b0}}, in_roaming, in_show};
                end
                mem_we       = 1'b1;
                count_d[cls] = count_q[cls] + 1'b1;
                total_d      = total_q + 1'b1;
              end
            end
            tcpcq_pkg::REQ_SERVE: begin
              // Pick the highest non-empty class
              if (count_q[2] != '0) begin
                cls = tcpcq_pkg::CLS_EMERG;
              end else if (count_q[1] != '0) begin
                cls = tcpcq_pkg::CLS_VOICE;
              end else begin
                cls = tcpcq_pkg::CLS_DATA;
              end
              if (total_q == '0) begin
                m_tuser_d = tcpcq_pkg::ST_EMPTY;
              end else begin
                case (cls)
                  tcpcq_pkg::CLS_VOICE: base = BaseVoice;
                  tcpcq_pkg::CLS_EMERG: base = BaseEmerg;
                  default:              base = '0;
                endcase
                mem_addr     = base + AW'(head_q[cls]);
                mem_re       = 1'b1;
                head_inc     = {1'b0, head_q[cls]} + 1'b1;
                head_d[cls]  = (head_inc >= (HW + 1)'(CAPACITY)) ? '0 : head_inc[HW-1:0];
                count_d[cls] = count_q[cls] - 1'b1;
                total_d      = total_q - 1'b1;
                srv_cls_d    = tcpcq_pkg::class_e'(cls);
                // Result waits for the store read
                m_tvalid_d   = m_tready_i ? 1'b0 : m_tvalid_q;
                m_tdata_d    = m_tdata_q;
                m_tuser_d    = m_tuser_q;
                state_d      = tcpcq_pkg::FSM_SERVE;
              end
            end
            tcpcq_pkg::REQ_DISMISS: begin
              // Drop the lowest non-empty class among data and voice
              if (count_q[0] != '0) begin
                cls = tcpcq_pkg::CLS_DATA;
              end else begin
                cls = tcpcq_pkg::CLS_VOICE;
              end
              if (count_q[0] == '0 && count_q[1] == '0) begin
                m_tuser_d = tcpcq_pkg::ST_NO_DISMISS;
              end else begin
                dis_w        = {{DisW{1'b0}}, count_q[cls]};
                m_tdata_d[86:80] = dis_w[DisW-1:0];
                total_d      = total_q - count_q[cls];
                count_d[cls] = '0;
                head_d[cls]  = '0;
              end
            end
            default: begin
              m_tuser_d = tcpcq_pkg::ST_OK;
            end
          endcase
        end
      end
      tcpcq_pkg::FSM_SERVE: begin
        // Load the served record once the output register is free
        if (out_free) begin
          if (srv_cls_q == tcpcq_pkg::CLS_DATA) begin
            o_pkts = rd_extra_q[PktW+1:2];
          end
          if (srv_cls_q == tcpcq_pkg::CLS_VOICE) begin
            o_roam = rd_extra_q[1];
            o_show = rd_extra_q[0];
          end
          m_tvalid_d = 1'b1;
          m_tuser_d  = tcpcq_pkg::ST_OK;
          m_tdata_d  = {1'b0, {DisW{1'b0}}, o_show, o_roam, o_pkts,
                        rd_party_q[NumW-1:0], rd_party_q[2*NumW-1:NumW], srv_cls_q};
          state_d    = tcpcq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = tcpcq_pkg::FSM_IDLE;
      end
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      party_mem[mem_addr] <= wr_party;
      extra_mem[mem_addr] <= wr_extra;
    end
    if (mem_re) begin
      rd_party_q <= party_mem[mem_addr];
      rd_extra_q <= extra_mem[mem_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcpcq_pkg::FSM_IDLE;
      total_q    <= '0;
      m_tvalid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      m_tvalid_q <= m_tvalid_d;
      for (int i = 0; i < 3; i++) begin
        head_q[i]  <= head_d[i];
        count_q[i] <= count_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    srv_cls_q <= srv_cls_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  // Checks
  logic [CW+1:0] count_sum;
  assign count_sum = (CW + 2)'(count_q[0]) + (CW + 2)'(count_q[1]) + (CW + 2)'(count_q[2]);

  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_sum == (CW + 2)'(total_q))
    else $error("total held differs from sum of class counts");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CapCount)
    else $error("total held exceeds capacity");

  a_serve_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcpcq_pkg::FSM_SERVE |-> !s_tready_o)
    else $error("input ready while a serve read is pending");

  a_serve_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_tuser_i == tcpcq_pkg::REQ_SERVE && total_q != '0
    |=> state_q == tcpcq_pkg::FSM_SERVE && !$stable(total_q))
    else $error("serve of a held call did not start a store read");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH   = tcpcq_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS  = 490;
  localparam int unsigned QUIET_ITEMS   = 150;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [tcpcq_pkg::NumW-1:0]     NUM_MAX = 30'd999999999;
  localparam logic [tcpcq_pkg::PacketsW-1:0] PKT_MAX = 16'hFFFF;

  // One call record as it travels on the input stream
  typedef struct packed {
    logic [tcpcq_pkg::NumW-1:0]     calling;
    logic [tcpcq_pkg::NumW-1:0]     called;
    logic [tcpcq_pkg::PacketsW-1:0] packets;
    logic                           roaming;
    logic                           show;
  } call_t;

  // One result item, field by field
  typedef struct packed {
    tcpcq_pkg::status_e             status;
    tcpcq_pkg::class_e              cls;
    logic [tcpcq_pkg::NumW-1:0]     calling;
    logic [tcpcq_pkg::NumW-1:0]     called;
    logic [tcpcq_pkg::PacketsW-1:0] packets;
    logic                           roaming;
    logic                           show;
    logic [tcpcq_pkg::DismissW-1:0] dropped;
  } outcome_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           s_tvalid_i = 1'b0;
  logic                           s_tready_o;
  logic [tcpcq_pkg::InDataW-1:0]  s_tdata_i  = '0;
  logic [tcpcq_pkg::InUserW-1:0]  s_tuser_i  = '0;
  logic                           m_tvalid_o;
  logic                           m_tready_i = 1'b0;
  logic [tcpcq_pkg::OutDataW-1:0] m_tdata_o;
  logic [tcpcq_pkg::OutUserW-1:0] m_tuser_o;

  // Predicted queue contents, one FIFO per class
  call_t       class_fifo [3][$];
  outcome_t    pending_results [$];

  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold_request = 0;
  bit          sink_holding = 1'b0;

  int unsigned fail_count      = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned calls_served    = 0;
  int unsigned empty_serves    = 0;
  int unsigned dismissals      = 0;
  int unsigned refused_inserts = 0;
  int unsigned cycle_count     = 0;

  three_class_priority_call_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned calls_held();
    return class_fifo[tcpcq_pkg::CLS_DATA].size() + class_fifo[tcpcq_pkg::CLS_VOICE].size() +
           class_fifo[tcpcq_pkg::CLS_EMERG].size();
  endfunction

  // Apply one request to the predicted queue and return its result
  function automatic outcome_t predict_outcome(input logic [2:0] req, input call_t rec);
    outcome_t res;
    call_t    kept;
    int       lane;
    res  = '0;
    kept = rec;
    lane = -1;
    case (req)
      tcpcq_pkg::REQ_INS_DATA, tcpcq_pkg::REQ_INS_VOICE, tcpcq_pkg::REQ_INS_EMERG: begin
        if (calls_held() >= QUEUE_DEPTH) begin
          res.status = tcpcq_pkg::ST_FULL;
          refused_inserts++;
        end else begin
          // keep only the extras that this class carries
          if (req != tcpcq_pkg::REQ_INS_DATA) kept.packets = '0;
          if (req != tcpcq_pkg::REQ_INS_VOICE) begin
            kept.roaming = 1'b0;
            kept.show    = 1'b0;
          end
          class_fifo[req[1:0]].push_back(kept);
        end
      end
      tcpcq_pkg::REQ_SERVE: begin
        if (class_fifo[tcpcq_pkg::CLS_EMERG].size() != 0) lane = tcpcq_pkg::CLS_EMERG;
        else if (class_fifo[tcpcq_pkg::CLS_VOICE].size() != 0) lane = tcpcq_pkg::CLS_VOICE;
        else if (class_fifo[tcpcq_pkg::CLS_DATA].size() != 0) lane = tcpcq_pkg::CLS_DATA;
        if (lane < 0) begin
          res.status = tcpcq_pkg::ST_EMPTY;
          empty_serves++;
        end else begin
          kept = class_fifo[lane].pop_front();
          res.cls     = tcpcq_pkg::class_e'(lane);
          res.calling = kept.calling;
          res.called  = kept.called;
          res.packets = kept.packets;
          res.roaming = kept.roaming;
          res.show    = kept.show;
          calls_served++;
        end
      end
      tcpcq_pkg::REQ_DISMISS: begin
        // lowest non-empty class among data and voice
        if (class_fifo[tcpcq_pkg::CLS_DATA].size() != 0) lane = tcpcq_pkg::CLS_DATA;
        else if (class_fifo[tcpcq_pkg::CLS_VOICE].size() != 0) lane = tcpcq_pkg::CLS_VOICE;
        if (lane < 0) begin
          res.status = tcpcq_pkg::ST_NO_DISMISS;
        end else begin
          res.dropped = tcpcq_pkg::DismissW'(class_fifo[lane].size());
          class_fifo[lane].delete();
          dismissals++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic string describe(input outcome_t o);
    return $sformatf("st %0d cls %0d calling %0d called %0d pkts %0d roam %b cid %b drop %0d",
                     o.status, o.cls, o.calling, o.called, o.packets, o.roaming, o.show,
                     o.dropped);
  endfunction

  // Mostly uniform numbers, now and then an extreme
  function automatic logic [tcpcq_pkg::NumW-1:0] pick_number();
    case ($urandom_range(7))
      0:       return '0;
      1:       return NUM_MAX;
      default: return tcpcq_pkg::NumW'($urandom_range(NUM_MAX, 0));
    endcase
  endfunction

  function automatic call_t random_call();
    call_t c;
    c.calling = pick_number();
    c.called  = pick_number();
    c.packets = ($urandom_range(7) == 0) ? PKT_MAX :
                tcpcq_pkg::PacketsW'($urandom_range(PKT_MAX, 0));
    c.roaming = 1'($urandom_range(1));
    c.show    = 1'($urandom_range(1));
    return c;
  endfunction

  // Offer one item, hold it until taken, then maybe idle
  task automatic send_request(input logic [2:0] req, input call_t rec);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= req;
    s_tdata_i  <= {2'b00, rec.show, rec.roaming, rec.packets, rec.called, rec.calling};
    do @(posedge clk_i); while (s_tready_o !== 1'b1);
    pending_results.push_back(predict_outcome(req, rec));
    requests_sent++;
    if (src_idle_on && $urandom_range(3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
  endtask

  // Drive the output ready: random stalls, plus the long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_request != 0) begin
        stall_left        = sink_hold_request;
        sink_hold_request = 0;
        sink_holding      = 1'b1;
      end else if (stall_left == 0) begin
        sink_holding = 1'b0;
        if (sink_idle_on && $urandom_range(5) == 0) stall_left = $urandom_range(16, 1);
      end
      if (stall_left != 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Compare each result item against the oldest prediction
  initial begin : result_check
    outcome_t want;
    outcome_t got;
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o === 1'b1 && m_tready_i === 1'b1) begin
        got.status  = tcpcq_pkg::status_e'(m_tuser_o);
        got.cls     = tcpcq_pkg::class_e'(m_tdata_o[1:0]);
        got.calling = m_tdata_o[31:2];
        got.called  = m_tdata_o[61:32];
        got.packets = m_tdata_o[77:62];
        got.roaming = m_tdata_o[78];
        got.show    = m_tdata_o[79];
        got.dropped = m_tdata_o[86:80];
        results_checked++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %s", describe(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want || m_tdata_o[tcpcq_pkg::OutDataW-1] !== 1'b0) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch", results_checked);
              $display("  expected %s", describe(want));
              $display("  actual   %s pad %b", describe(got),
                       m_tdata_o[tcpcq_pkg::OutDataW-1]);
            end
          end
        end
      end
    end
  end

  // Serve and dismiss on an empty queue, and the unknown request codes
  task automatic test_empty_and_unknown();
    send_request(tcpcq_pkg::REQ_SERVE, random_call());
    send_request(tcpcq_pkg::REQ_DISMISS, random_call());
    for (int k = 1; k <= 3; k++) send_request(tcpcq_pkg::REQ_DISMISS + 3'(k), random_call());
  endtask

  // Priority order, class extras and dismiss selection with field extremes
  task automatic test_class_order();
    send_request(tcpcq_pkg::REQ_INS_EMERG, call_t'{NUM_MAX, NUM_MAX, PKT_MAX, 1'b1, 1'b1});
    send_request(tcpcq_pkg::REQ_DISMISS, '0);
    send_request(tcpcq_pkg::REQ_INS_DATA, call_t'{'0, NUM_MAX, PKT_MAX, 1'b1, 1'b1});
    send_request(tcpcq_pkg::REQ_INS_VOICE, call_t'{NUM_MAX, '0, PKT_MAX, 1'b1, 1'b0});
    send_request(tcpcq_pkg::REQ_INS_VOICE, call_t'{30'd12345, 30'd678, '0, 1'b0, 1'b1});
    send_request(tcpcq_pkg::REQ_INS_DATA, call_t'{NUM_MAX, '0, '0, 1'b0, 1'b0});
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_DISMISS, '0);
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_INS_DATA, call_t'{'0, '0, 16'd1, 1'b0, 1'b0});
    send_request(tcpcq_pkg::REQ_INS_VOICE, call_t'{'0, '0, '0, 1'b1, 1'b1});
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_SERVE, '0);
    send_request(tcpcq_pkg::REQ_INS_VOICE, random_call());
    send_request(tcpcq_pkg::REQ_DISMISS, '0);
    send_request(tcpcq_pkg::REQ_DISMISS, '0);
  endtask

  // Fill each class to capacity, refuse, wrap its ring, then clear it
  task automatic test_full_store();
    logic [2:0] ins;
    for (int k = tcpcq_pkg::CLS_DATA; k <= tcpcq_pkg::CLS_EMERG; k++) begin
      ins = tcpcq_pkg::REQ_INS_DATA + 3'(k);
      while (calls_held() < QUEUE_DEPTH) send_request(ins, random_call());
      for (int j = 0; j < 3; j++) begin
        send_request(tcpcq_pkg::REQ_INS_DATA + 3'(j), random_call());
      end
      repeat (40) send_request(tcpcq_pkg::REQ_SERVE, random_call());
      while (calls_held() < QUEUE_DEPTH) send_request(ins, random_call());
      if (k == tcpcq_pkg::CLS_EMERG) begin
        repeat (QUEUE_DEPTH + 1) send_request(tcpcq_pkg::REQ_SERVE, random_call());
      end else begin
        send_request(tcpcq_pkg::REQ_DISMISS, random_call());
      end
    end
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_backpressure();
    src_idle_on       = 1'b0;
    sink_idle_on      = 1'b0;
    sink_hold_request = HOLD_CYCLES;
    s_tvalid_i <= 1'b0;
    while (!sink_holding) @(posedge clk_i);
    repeat (30) begin
      if ($urandom_range(1) == 0) send_request(tcpcq_pkg::REQ_SERVE, random_call());
      else send_request(tcpcq_pkg::REQ_INS_DATA + 3'($urandom_range(2)), random_call());
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Random traffic in phases that push the queue up or drain it
  task automatic test_random_traffic();
    int unsigned fill_pct;
    int unsigned pick;
    logic [2:0]  req;
    fill_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0:       fill_pct = 15;
          1:       fill_pct = 45;
          2:       fill_pct = 60;
          default: fill_pct = 88;
        endcase
      end
      // no idling in the closing stretch
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < fill_pct) req = tcpcq_pkg::REQ_INS_DATA + 3'($urandom_range(2));
      else if (pick < fill_pct + 7) req = tcpcq_pkg::REQ_DISMISS;
      else if (pick < fill_pct + 9) req = tcpcq_pkg::REQ_DISMISS + 3'($urandom_range(3, 1));
      else req = tcpcq_pkg::REQ_SERVE;
      send_request(req, random_call());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_unknown();
    test_class_order();
    test_full_store();
    test_backpressure();
    test_random_traffic();

    // Let the last results drain
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results checked: %0d calls served, %0d empty serves,",
             requests_sent, results_checked, calls_served, empty_serves);
    $display("%0d dismissals, %0d inserts refused on a full queue, %0d mismatches",
             dismissals, refused_inserts, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
